// ===== design/rme_pkg.sv =====
// ----------------------------------------------------------------------------
// rme_pkg
// Shared constants, opcode names and request structures of the execute unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rme_pkg;

   // Storage geometry
   localparam int REG_COUNT  = 256;
   localparam int REG_AW     = $clog2(REG_COUNT);
   localparam int MEM_DEPTH  = 65536;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);
   localparam int WORD_W     = 16;

   // Register that holds the stack pointer right after reset
   localparam logic [REG_AW-1:0] RF_STACK_RESET = REG_AW'(254);
   localparam logic [WORD_W-1:0] STACK_INIT     = 16'hFFFF;

   // Instruction groups
   localparam logic [2:0] OP_ARITH = 3'd0;
   localparam logic [2:0] OP_MOVE  = 3'd1;
   localparam logic [2:0] OP_JUMP  = 3'd2;
   localparam logic [2:0] OP_CMP   = 3'd3;
   localparam logic [2:0] OP_MISC  = 3'd4;

   // Arithmetic operations
   localparam logic [4:0] A_ADD  = 5'd0;
   localparam logic [4:0] A_SUB  = 5'd1;
   localparam logic [4:0] A_MUL  = 5'd2;
   localparam logic [4:0] A_DIV  = 5'd3;
   localparam logic [4:0] A_REM  = 5'd4;
   localparam logic [4:0] A_SHL  = 5'd5;
   localparam logic [4:0] A_SHR  = 5'd6;
   localparam logic [4:0] A_AND  = 5'd7;
   localparam logic [4:0] A_OR   = 5'd8;
   localparam logic [4:0] A_NOT  = 5'd9;
   localparam logic [4:0] A_XOR  = 5'd10;
   localparam logic [4:0] A_ADDI = 5'd11;
   localparam logic [4:0] A_DIVI = 5'd14;
   localparam logic [4:0] A_REMI = 5'd15;
   localparam logic [4:0] A_SHLI = 5'd16;
   localparam logic [4:0] A_SHRI = 5'd17;
   localparam logic [4:0] A_LAST = 5'd17;

   // Move operations
   localparam logic [4:0] M_MOVE       = 5'd0;
   localparam logic [4:0] M_SWAP       = 5'd1;
   localparam logic [4:0] M_SWAP_RA    = 5'd2;
   localparam logic [4:0] M_SWAP_AA    = 5'd3;
   localparam logic [4:0] M_SWAP_RM    = 5'd4;
   localparam logic [4:0] M_SWAP_AM    = 5'd5;
   localparam logic [4:0] M_SET        = 5'd6;
   localparam logic [4:0] M_LOAD       = 5'd7;
   localparam logic [4:0] M_LOAD_MEM   = 5'd8;
   localparam logic [4:0] M_STORE      = 5'd9;
   localparam logic [4:0] M_STORE_ADDR = 5'd10;
   localparam logic [4:0] M_MEMCOPY    = 5'd11;
   localparam logic [4:0] M_MEMSET     = 5'd12;
   localparam logic [4:0] M_PUSH       = 5'd13;
   localparam logic [4:0] M_PUSH_IMM   = 5'd14;
   localparam logic [4:0] M_POP        = 5'd15;

   // Jump operations
   localparam logic [4:0] J_UNCOND = 5'd0;
   localparam logic [4:0] J_COND   = 5'd1;
   localparam logic [4:0] J_ITE    = 5'd2;

   // Compare operations
   localparam logic [4:0] C_EQ = 5'd0;
   localparam logic [4:0] C_NE = 5'd1;
   localparam logic [4:0] C_LT = 5'd2;
   localparam logic [4:0] C_GT = 5'd3;
   localparam logic [4:0] C_LE = 5'd4;
   localparam logic [4:0] C_GE = 5'd5;

   // Compare combine modes
   localparam logic [1:0] CB_SET = 2'd0;
   localparam logic [1:0] CB_AND = 2'd1;
   localparam logic [1:0] CB_OR  = 2'd2;
   localparam logic [1:0] CB_XOR = 2'd3;

   // Misc operations and system calls
   localparam logic [4:0] X_SYSCALL = 5'd0;
   localparam logic [2:0] SYS_TERM  = 3'd0;
   localparam logic [2:0] SYS_GETC  = 3'd1;
   localparam logic [2:0] SYS_PUTC  = 3'd2;

   // Error codes
   localparam logic [3:0] ERR_NONE    = 4'd0;
   localparam logic [3:0] ERR_GROUP   = 4'd1;
   localparam logic [3:0] ERR_ARITH   = 4'd2;
   localparam logic [3:0] ERR_MOVE    = 4'd3;
   localparam logic [3:0] ERR_JUMP    = 4'd4;
   localparam logic [3:0] ERR_CMP     = 4'd5;
   localparam logic [3:0] ERR_MISC    = 4'd7;
   localparam logic [3:0] ERR_SYSCALL = 4'd8;

   // Configuration register indexes
   localparam logic CSR_PRED  = 1'b0;
   localparam logic CSR_STACK = 1'b1;

   // Register file access for one cycle
   typedef struct packed {
      logic              re;
      logic [REG_AW-1:0] ra0;
      logic [REG_AW-1:0] ra1;
      logic              we;
      logic [REG_AW-1:0] wa;
      logic [WORD_W-1:0] wd;
   } rf_req_type;

   // Data and stack memory access for one cycle
   typedef struct packed {
      logic              d_re;
      logic              d_we;
      logic [MEM_AW-1:0] d_addr;
      logic [WORD_W-1:0] d_wdata;
      logic              s_re;
      logic              s_we;
      logic [MEM_AW-1:0] s_addr;
      logic [WORD_W-1:0] s_wdata;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== design/register_machine_execute_unit_core.sv =====
// ----------------------------------------------------------------------------
// register_machine_execute_unit_core
// Executes one pre-decoded instruction per item against the register file,
// data memory, stack memory, program counter and halt flag.
// ----------------------------------------------------------------------------
//  channel  | direction | carries
//  req_     | in        | one decoded instruction per item
//  rsp_     | out       | next pc, halt, character and error status per item
//  csr_     | in/out    | predicate and stack register indexes
//
//  An item is accepted only in IDLE, once the previous item has left WR2. The
//  sequencer reads the register file (RD1, RD2), the data and stack memories
//  (MD1, MD2), waits in DIV for the 16-step divider on divide and remainder,
//  computes (CALC), then writes back (WR1, WR2). After reset the memories are
//  zero-filled, during which no item is accepted. A stalled result holds the
//  last write-back step, while the result register lets the next item in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module register_machine_execute_unit_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[2:0] sub_op[7:3] reg_a[15:8] reg_b[23:16] reg_c[31:24] immediate[47:32]
   // link_flag[48] imm_flag[49] true_flag[50] combine_mode[52:51]
   // syscall_index[55:53] char_in[71:56]
   input  wire logic [71:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // next_pc[15:0] halted[16] char_out_valid[17] char_out[25:18]
   // char_in_used[26] error_code[30:27], zero [31]
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import rme_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RD1  = 4'd1;
   localparam logic [3:0] ST_RD2  = 4'd2;
   localparam logic [3:0] ST_MD1  = 4'd3;
   localparam logic [3:0] ST_MD2  = 4'd4;
   localparam logic [3:0] ST_DIV  = 4'd5;
   localparam logic [3:0] ST_CALC = 4'd6;
   localparam logic [3:0] ST_WR1  = 4'd7;
   localparam logic [3:0] ST_WR2  = 4'd8;

   logic [3:0] state_ff, state_in;

   // Configuration registers
   logic [REG_AW-1:0] pred_ff, stk_ff;

   // Latched instruction
   logic [2:0]  op_ff;
   logic [4:0]  sub_ff;
   logic [7:0]  a_ff, b_ff, c_ff;
   logic [15:0] imm_ff, chin_ff;
   logic        lnk_ff, im_ff, tf_ff;
   logic [1:0]  mode_ff;
   logic [2:0]  sys_ff;

   // Architectural state
   logic [15:0] pc_ff;
   logic        halt_ff;

   // Operands
   logic [15:0] rx_ff, d0_ff, ry, rz, d1, sd;
   logic [15:0] q0, q1, d_q, s_q;

   // Write-back plan
   logic        w0en_ff, w1en_ff, m0en_ff, m0stk_ff, m1en_ff;
   logic [7:0]  w0a_ff, w1a_ff;
   logic [15:0] w0d_ff, w1d_ff, m0a_ff, m0d_ff, m1a_ff, m1d_ff;
   logic        w0en_in, w1en_in, m0en_in, m0stk_in, m1en_in;
   logic [7:0]  w0a_in, w1a_in;
   logic [15:0] w0d_in, w1d_in, m0a_in, m0d_in, m1a_in, m1d_in;
   logic [15:0] npc_ff, npc_in;
   logic        hres_ff, hres_in;
   logic        cov_ff, cov_in, ciu_ff, ciu_in;
   logic [7:0]  co_ff, co_in;
   logic [3:0]  err_ff, err_in;

   // Result register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff;

   rf_req_type  rf_req;
   mem_req_type mem_req;
   logic        mem_busy, div_busy, div_start;
   logic [15:0] quo, rmd;

   logic        accept, fire, uses_p, needs_div;
   logic [7:0]  ix, iz;
   logic [15:0] dp0, dp1, pc1;

   assign accept = req_tvalid && req_tready;
   assign fire   = (state_ff == ST_WR2) && (!rsp_valid_ff || rsp_tready);
   assign pc1    = pc_ff + 16'd1;

   // Read index selection
   assign uses_p = (op_ff == OP_JUMP) &&
                   (((sub_ff == J_COND) && lnk_ff && im_ff) ||
                    ((sub_ff == J_ITE) && lnk_ff));
   assign ix = uses_p ? pred_ff : a_ff;
   assign iz = (op_ff == OP_MOVE) ? stk_ff : c_ff;
   assign ry = q1;
   assign rz = q0;
   assign d1 = d_q;
   assign sd = s_q;

   assign needs_div = (op_ff == OP_ARITH) &&
                      ((sub_ff == A_DIV) || (sub_ff == A_REM) ||
                       (sub_ff == A_DIVI) || (sub_ff == A_REMI));
   assign div_start = (state_ff == ST_MD2) && needs_div;

   // Data memory addresses for the two read slots
   always_comb begin
      case (sub_ff)
         M_SWAP_RA, M_LOAD, M_STORE_ADDR: dp0 = ry;
         M_SWAP_AA, M_SWAP_AM:            dp0 = rx_ff;
         default:                         dp0 = imm_ff;
      endcase
      dp1 = (sub_ff == M_SWAP_AA) ? ry : imm_ff;
   end

   // Handshake and sequencer
   assign req_tready = (state_ff == ST_IDLE) && !mem_busy;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_RD1;
         ST_RD1:  state_in = ST_RD2;
         ST_RD2:  state_in = ST_MD1;
         ST_MD1:  state_in = ST_MD2;
         ST_MD2:  state_in = needs_div ? ST_DIV : ST_CALC;
         ST_DIV:  if (!div_busy) state_in = ST_CALC;
         ST_CALC: state_in = ST_WR1;
         ST_WR1:  state_in = ST_WR2;
         ST_WR2:  if (fire) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            pc_ff        <= npc_ff;
            halt_ff      <= hres_ff;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         pred_ff <= REG_AW'(255);
         stk_ff  <= RF_STACK_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == CSR_PRED) begin
            pred_ff <= csr_pwdata[REG_AW-1:0];
         end else begin
            stk_ff <= csr_pwdata[REG_AW-1:0];
         end
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = {24'd0, (csr_paddr[2] == CSR_STACK) ? stk_ff : pred_ff};

   // Payload capture
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_tdata[2:0];
         sub_ff  <= req_tdata[7:3];
         a_ff    <= req_tdata[15:8];
         b_ff    <= req_tdata[23:16];
         c_ff    <= req_tdata[31:24];
         imm_ff  <= req_tdata[47:32];
         lnk_ff  <= req_tdata[48];
         im_ff   <= req_tdata[49];
         tf_ff   <= req_tdata[50];
         mode_ff <= req_tdata[52:51];
         sys_ff  <= req_tdata[55:53];
         chin_ff <= req_tdata[71:56];
      end
      if (state_ff == ST_RD2) rx_ff <= q0;
      if (state_ff == ST_MD2) d0_ff <= d_q;
      if (state_ff == ST_CALC) begin
         w0en_ff  <= w0en_in;  w0a_ff <= w0a_in;  w0d_ff <= w0d_in;
         w1en_ff  <= w1en_in;  w1a_ff <= w1a_in;  w1d_ff <= w1d_in;
         m0en_ff  <= m0en_in;  m0a_ff <= m0a_in;  m0d_ff <= m0d_in;
         m0stk_ff <= m0stk_in;
         m1en_ff  <= m1en_in;  m1a_ff <= m1a_in;  m1d_ff <= m1d_in;
         npc_ff   <= npc_in;   hres_ff <= hres_in;
         cov_ff   <= cov_in;   co_ff  <= co_in;   ciu_ff <= ciu_in;
         err_ff   <= err_in;
      end
      if (fire) begin
         rsp_data_ff <= {1'b0, err_ff, ciu_ff, co_ff, cov_ff, hres_ff, npc_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // ALU for register and immediate forms
   function automatic logic [15:0] alu(input logic [4:0] k, input logic [15:0] x,
                                       input logic [15:0] y, input logic [15:0] q,
                                       input logic [15:0] r);
      logic [31:0] prod;
      prod = x * y;
      case (k)
         A_ADD:   alu = x + y;
         A_SUB:   alu = x - y;
         A_MUL:   alu = prod[15:0];
         A_DIV:   alu = q;
         A_REM:   alu = r;
         A_SHL:   alu = (y >= 16'd16) ? 16'd0 : (x << y[3:0]);
         A_SHR:   alu = (y >= 16'd16) ? 16'd0 : (x >> y[3:0]);
         A_AND:   alu = x & y;
         A_OR:    alu = x | y;
         default: alu = x ^ y;
      endcase
   endfunction

   // Execute: plan write-back and result
   always_comb begin
      logic [15:0] pv, tv, cr;
      logic        taken, sel_b, cv;
      logic [7:0]  idx;

      w0en_in = 1'b0; w0a_in = a_ff; w0d_in = '0;
      w1en_in = 1'b0; w1a_in = a_ff; w1d_in = '0;
      m0en_in = 1'b0; m0a_in = rx_ff; m0d_in = '0; m0stk_in = 1'b0;
      m1en_in = 1'b0; m1a_in = imm_ff; m1d_in = '0;
      npc_in  = pc1;  hres_in = 1'b0;
      cov_in  = 1'b0; co_in = '0; ciu_in = 1'b0;
      err_in  = ERR_NONE;
      pv = '0; tv = '0; cr = '0; taken = 1'b0; sel_b = 1'b0; cv = 1'b0; idx = '0;

      // Decode-time faults
      case (op_ff)
         OP_ARITH: if (sub_ff > A_LAST) err_in = ERR_ARITH;
         OP_MOVE:  if (sub_ff > M_POP) err_in = ERR_MOVE;
         OP_JUMP:  if (sub_ff > J_ITE) err_in = ERR_JUMP;
         OP_CMP:   if (sub_ff > C_GE) err_in = ERR_CMP;
         OP_MISC: begin
            if (sub_ff != X_SYSCALL) err_in = ERR_MISC;
            else if (!(sys_ff inside {SYS_TERM, SYS_GETC, SYS_PUTC}))
               err_in = ERR_SYSCALL;
         end
         default: err_in = ERR_GROUP;
      endcase

      case (op_ff)
         OP_ARITH: begin
            w0en_in = 1'b1;
            if (sub_ff == A_NOT) w0d_in = ~ry;
            else if (sub_ff < A_ADDI) w0d_in = alu(sub_ff, ry, rz, quo, rmd);
            else w0d_in = alu(sub_ff - A_ADDI, ry, imm_ff, quo, rmd);
         end
         OP_MOVE: begin
            case (sub_ff)
               M_MOVE: begin w0en_in = 1'b1; w0d_in = ry; end
               M_SWAP: begin
                  w0en_in = 1'b1; w0d_in = ry;
                  w1en_in = 1'b1; w1a_in = b_ff; w1d_in = rx_ff;
               end
               M_SWAP_RA: begin
                  w0en_in = 1'b1; w0d_in = d0_ff;
                  m0en_in = 1'b1; m0a_in = ry; m0d_in = rx_ff;
               end
               M_SWAP_AA: begin
                  m0en_in = 1'b1; m0a_in = rx_ff; m0d_in = d1;
                  m1en_in = 1'b1; m1a_in = ry; m1d_in = d0_ff;
               end
               M_SWAP_RM: begin
                  w0en_in = 1'b1; w0d_in = d0_ff;
                  m0en_in = 1'b1; m0a_in = imm_ff; m0d_in = rx_ff;
               end
               M_SWAP_AM: begin
                  m0en_in = 1'b1; m0a_in = rx_ff; m0d_in = d1;
                  m1en_in = 1'b1; m1a_in = imm_ff; m1d_in = d0_ff;
               end
               M_SET: begin w0en_in = 1'b1; w0d_in = imm_ff; end
               M_LOAD, M_LOAD_MEM: begin w0en_in = 1'b1; w0d_in = d0_ff; end
               M_STORE: begin m0en_in = 1'b1; m0d_in = ry; end
               M_STORE_ADDR, M_MEMCOPY: begin m0en_in = 1'b1; m0d_in = d0_ff; end
               M_MEMSET: begin m0en_in = 1'b1; m0d_in = imm_ff; end
               M_PUSH, M_PUSH_IMM: begin
                  m0en_in = 1'b1; m0stk_in = 1'b1; m0a_in = rz + 16'd1;
                  m0d_in  = (sub_ff == M_PUSH) ? rx_ff : imm_ff;
                  w0en_in = 1'b1; w0a_in = stk_ff; w0d_in = rz + 16'd1;
               end
               default: begin
                  // pop: stack pointer first, then destination
                  w0en_in = 1'b1; w0a_in = stk_ff; w0d_in = rz - 16'd1;
                  w1en_in = 1'b1; w1d_in = sd;
               end
            endcase
         end
         OP_JUMP: begin
            case (sub_ff)
               J_UNCOND: begin
                  if (lnk_ff) begin
                     w0en_in = 1'b1; w0d_in = pc1;
                     npc_in = im_ff ? imm_ff : ((b_ff == a_ff) ? pc1 : ry);
                  end else begin
                     npc_in = im_ff ? imm_ff : rx_ff;
                  end
               end
               J_COND: begin
                  pv    = rx_ff;
                  taken = tf_ff ? (pv != 16'd0) : (pv == 16'd0);
                  if (taken) begin
                     if (lnk_ff && im_ff) begin
                        w0en_in = 1'b1; w0d_in = pc1; npc_in = imm_ff;
                     end else if (lnk_ff) begin
                        w0en_in = 1'b1; w0a_in = b_ff; w0d_in = pc1; npc_in = rz;
                     end else begin
                        npc_in = im_ff ? imm_ff : ry;
                     end
                  end
               end
               default: begin
                  // if-then-else: link written before the target is read
                  sel_b = (rx_ff != 16'd0) ? tf_ff : !tf_ff;
                  idx   = sel_b ? b_ff : c_ff;
                  tv    = sel_b ? ry : rz;
                  if (lnk_ff) begin
                     w0en_in = 1'b1; w0d_in = pc1;
                     if (idx == a_ff) tv = pc1;
                  end
                  npc_in = tv;
               end
            endcase
         end
         OP_CMP: begin
            case (sub_ff)
               C_EQ:    cv = (ry == rz);
               C_NE:    cv = (ry != rz);
               C_LT:    cv = (ry < rz);
               C_GT:    cv = (ry > rz);
               C_LE:    cv = (ry <= rz);
               default: cv = (ry >= rz);
            endcase
            cr = {15'd0, cv};
            w0en_in = 1'b1;
            case (mode_ff)
               CB_SET:  w0d_in = cr;
               CB_AND:  w0d_in = cr & rx_ff;
               CB_OR:   w0d_in = cr | rx_ff;
               default: w0d_in = cr ^ rx_ff;
            endcase
         end
         default: begin
            case (sys_ff)
               SYS_TERM: hres_in = 1'b1;
               SYS_GETC: begin w0en_in = 1'b1; w0d_in = chin_ff; ciu_in = 1'b1; end
               default:  begin co_in = rx_ff[7:0]; cov_in = 1'b1; end
            endcase
         end
      endcase

      // Halted or faulting items write no register or memory, keep the pc and set halt
      if (halt_ff || (err_in != ERR_NONE)) begin
         w0en_in = 1'b0; w1en_in = 1'b0; m0en_in = 1'b0; m1en_in = 1'b0;
         npc_in  = pc_ff; hres_in = 1'b1;
         cov_in  = 1'b0; co_in = '0; ciu_in = 1'b0;
         if (halt_ff) err_in = ERR_NONE;
      end
   end

   // Register file port control
   always_comb begin
      rf_req.re  = (state_ff == ST_RD1) || (state_ff == ST_RD2);
      rf_req.ra0 = (state_ff == ST_RD1) ? ix : iz;
      rf_req.ra1 = b_ff;
      rf_req.we  = ((state_ff == ST_WR1) && w0en_ff) || (fire && w1en_ff);
      rf_req.wa  = (state_ff == ST_WR1) ? w0a_ff : w1a_ff;
      rf_req.wd  = (state_ff == ST_WR1) ? w0d_ff : w1d_ff;
   end

   // Memory port control
   always_comb begin
      mem_req.d_re    = (state_ff == ST_MD1) || (state_ff == ST_MD2);
      mem_req.d_we    = ((state_ff == ST_WR1) && m0en_ff && !m0stk_ff) ||
                        (fire && m1en_ff);
      if (state_ff == ST_WR1) begin
         mem_req.d_addr = m0a_ff;
      end else if (state_ff == ST_WR2) begin
         mem_req.d_addr = m1a_ff;
      end else if (state_ff == ST_MD1) begin
         mem_req.d_addr = dp0;
      end else begin
         mem_req.d_addr = dp1;
      end
      mem_req.d_wdata = (state_ff == ST_WR1) ? m0d_ff : m1d_ff;
      mem_req.s_re    = (state_ff == ST_MD1);
      mem_req.s_we    = (state_ff == ST_WR1) && m0en_ff && m0stk_ff;
      mem_req.s_addr  = (state_ff == ST_WR1) ? m0a_ff : rz;
      mem_req.s_wdata = m0d_ff;
   end

   rme_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .req   (rf_req),
      .q0    (q0),
      .q1    (q1)
   );

   rme_memory u_memory (
      .clock (clock),
      .reset (reset),
      .req   (mem_req),
      .busy  (mem_busy),
      .d_q   (d_q),
      .s_q   (s_q)
   );

   rme_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (ry),
      .divisor   ((sub_ff >= A_ADDI) ? imm_ff : rz),
      .busy      (div_busy),
      .quotient  (quo),
      .remainder (rmd)
   );

endmodule

`default_nettype wire

// ===== design/rme_regfile.sv =====
// ----------------------------------------------------------------------------
// rme_regfile
// Register file: two registered read ports, one write port, reset by valid bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rme_regfile (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rme_pkg::rf_req_type req,
   output logic [15:0]              q0,
   output logic [15:0]              q1
);
   import rme_pkg::*;

   logic [WORD_W-1:0]    rf_mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [WORD_W-1:0]    q0_ff, q1_ff;
   logic                 v0_ff, v1_ff, s0_ff, s1_ff;

   // Valid bits: an entry never written reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.we) begin
         valid_ff[req.wa] <= 1'b1;
      end
   end

   // Array write and registered reads
   always_ff @(posedge clock) begin
      if (req.we) begin
         rf_mem[req.wa] <= req.wd;
      end
      if (req.re) begin
         q0_ff <= rf_mem[req.ra0];
         q1_ff <= rf_mem[req.ra1];
         v0_ff <= valid_ff[req.ra0];
         v1_ff <= valid_ff[req.ra1];
         s0_ff <= (req.ra0 == RF_STACK_RESET);
         s1_ff <= (req.ra1 == RF_STACK_RESET);
      end
   end

   assign q0 = v0_ff ? q0_ff : (s0_ff ? STACK_INIT : '0);
   assign q1 = v1_ff ? q1_ff : (s1_ff ? STACK_INIT : '0);

endmodule

`default_nettype wire

// ===== design/rme_memory.sv =====
// ----------------------------------------------------------------------------
// rme_memory
// Data and stack word memories with a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rme_memory (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rme_pkg::mem_req_type req,
   output logic                      busy,
   output logic [15:0]               d_q,
   output logic [15:0]               s_q
);
   import rme_pkg::*;

   logic [WORD_W-1:0] data_mem  [MEM_DEPTH];
   logic [WORD_W-1:0] stack_mem [MEM_DEPTH];
   logic [MEM_AW-1:0] clr_cnt_ff;
   logic              clr_busy_ff;
   logic [WORD_W-1:0] d_q_ff, s_q_ff;

   // Clear sweep: one entry of each memory per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == MEM_AW'(MEM_DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // Data memory
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         data_mem[clr_cnt_ff] <= '0;
      end else if (req.d_we) begin
         data_mem[req.d_addr] <= req.d_wdata;
      end
      if (req.d_re) begin
         d_q_ff <= data_mem[req.d_addr];
      end
   end

   // Stack memory
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         stack_mem[clr_cnt_ff] <= '0;
      end else if (req.s_we) begin
         stack_mem[req.s_addr] <= req.s_wdata;
      end
      if (req.s_re) begin
         s_q_ff <= stack_mem[req.s_addr];
      end
   end

   assign busy = clr_busy_ff;
   assign d_q  = d_q_ff;
   assign s_q  = s_q_ff;

endmodule

`default_nettype wire

// ===== design/rme_divider.sv =====
// ----------------------------------------------------------------------------
// rme_divider
// Restoring 16-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rme_divider (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [15:0] dividend,
   input  wire logic [15:0] divisor,
   output logic             busy,
   output logic [15:0]      quotient,
   output logic [15:0]      remainder
);
   import rme_pkg::*;

   logic [4:0]        cnt_ff;
   logic              busy_ff;
   logic [WORD_W-1:0] rem_ff, quo_ff, dvs_ff;
   logic [WORD_W:0]   trial;
   logic              fits;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   // A zero divisor always fits, which yields all ones and the dividend back.
   assign trial = {rem_ff, quo_ff[WORD_W-1]};
   assign fits  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= 5'(WORD_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == 5'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= fits ? WORD_W'(trial - {1'b0, dvs_ff}) : trial[WORD_W-1:0];
         quo_ff <= {quo_ff[WORD_W-2:0], fits};
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire
